### sv/tsdr_pkg.sv
// Shared types, codes and edge-walk helpers for the triangle scanline depth rasteriser.
package tsdr_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_STEP      = 2'd1,
        CMD_SET_DEPTH = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [9:0] SCREEN_WIDTH_RST  = 10'd320;
    localparam logic [8:0] SCREEN_HEIGHT_RST = 9'd240;

    localparam logic [31:0] COLOR_BASE = 32'hFFF0_0000;
    localparam int          FRAC_BITS  = 24;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SORT,
        S_INIT,
        S_DIV01,
        S_DIV02,
        S_ROW_A,
        S_SLOPE12,
        S_ROW_B,
        S_SPAN,
        S_SPAN_DIV,
        S_ADDR,
        S_READ,
        S_CMP,
        S_SET,
        S_EMIT
    } t_state;

    // Bresenham walker: position, run lengths, directions and error term
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [18:0] err;
        logic               sx_neg;
        logic               sy_neg;
        logic               leg;
    } t_walker;

    // Point the walker at a new target from where it stands
    function automatic t_walker walk_aim(input t_walker w, input logic signed [15:0] tx,
                                         input logic signed [15:0] ty);
        t_walker            n;
        logic signed [16:0] ddx;
        logic signed [16:0] ddy;
        n        = w;
        ddx      = 17'(tx) - 17'(w.x);
        ddy      = 17'(ty) - 17'(w.y);
        n.dx     = 18'((ddx < 0) ? -ddx : ddx);
        n.dy     = 18'((ddy < 0) ? -ddy : ddy);
        n.sx_neg = !(w.x < tx);
        n.sy_neg = !(w.y < ty);
        n.err    = (n.dx > n.dy) ? 19'(n.dx >>> 1) : -19'(n.dy >>> 1);
        return n;
    endfunction

    // True when the next step moves the walker to a new row
    function automatic logic walk_moves(input t_walker w);
        return w.err < 19'(w.dy);
    endfunction

    function automatic t_walker walk_step(input t_walker w);
        t_walker            n;
        logic signed [18:0] t;
        n = w;
        t = w.err;
        if (t > -19'(w.dx)) begin
            n.err = n.err - 19'(w.dy);
            n.x   = w.sx_neg ? w.x - 16'sd1 : w.x + 16'sd1;
        end
        if (t < 19'(w.dy)) begin
            n.err = n.err + 19'(w.dx);
            n.y   = w.sy_neg ? w.y - 16'sd1 : w.y + 16'sd1;
        end
        return n;
    endfunction

endpackage

### sv/tsdr_depth_mem.sv
// Depth store: one write port and one registered read port.
module tsdr_depth_mem #(
    parameter int ADDR_W = 17,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tsdr_divider.sv
// Signed restoring divider, one quotient bit a cycle, truncating toward zero.
module tsdr_divider #(
    parameter int NUM_W = 58,
    parameter int DEN_W = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_zero;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;

    always_comb begin
        rem_sh = {r_rem, r_q[NUM_W-1]};
        q_bit  = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= (i_num < 0) ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_neg  <= i_num < 0;
            r_zero <= i_den == '0;
            r_den  <= i_den;
            r_rem  <= '0;
            r_cnt  <= CNT_W'(NUM_W - 1);
        end else if (r_busy) begin
            r_rem <= q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
            r_q   <= {r_q[NUM_W-2:0], q_bit};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : (r_neg ? -$signed(r_q) : $signed(r_q));

endmodule

### sv/triangle_scanline_depth_raster_unit.sv
// Triangle scanline rasteriser: edge walking, span depth stepping and depth-tested pixel writes.
// A pixel step runs the address, read and compare states, plus, at a row end, the edge walk steps,
// span set-up and a span slope division; a load sorts the vertices and takes two such
// divisions (a third where edge A turns at v1) and the first row. Depth set writes, then emits.
// One word is handled at a time; the next is taken once the result is in the output register.
// Reset clears control at once, then writes the farthest depth into depth store entries 0 to
// MAX_WIDTH*MAX_HEIGHT-1, with no input word taken.
module triangle_scanline_depth_raster_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata, low bit up: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  logic [167:0] i_s_axis_tdata,
    // tuser: cmd
    input  logic [1:0]   i_s_axis_tuser,
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata, low bit up: pixel_x, pixel_y, pixel_depth, pixel_color, zero fill
    output logic [79:0]  o_m_axis_tdata,
    // tuser: write_enable
    output logic         o_m_axis_tuser,
    // tlast: triangle_done
    output logic         o_m_axis_tlast,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [9:0]   i_cfg_wdata
);

    localparam int ACCW    = DEPTH_BITS + 34;             // edge and span depth accumulators
    localparam int FRAC    = tsdr_pkg::FRAC_BITS;
    localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(ENTRIES);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int CWW     = (WW > 10) ? WW : 10;
    localparam int CHW     = (HW > 9) ? HW : 9;
    localparam int KXW     = (WW > 16) ? WW : 16;
    localparam int KYW     = (HW > 16) ? HW : 16;
    localparam logic [DEPTH_BITS-1:0] DMAX = '1;

    tsdr_pkg::t_state r_state, n_state;

    // configuration
    logic [9:0] r_screen_w;
    logic [8:0] r_screen_h;

    // captured input word
    logic signed [15:0]     r_in_x [3];
    logic signed [15:0]     r_in_y [3];
    logic [DEPTH_BITS-1:0]  r_in_z [3];

    // sorted vertices
    logic signed [15:0]     r_vx [3];
    logic signed [15:0]     r_vy [3];
    logic [DEPTH_BITS-1:0]  r_vz [3];

    // edge walkers and depths
    tsdr_pkg::t_walker      r_wa, r_wb;
    logic signed [15:0]     r_xa, r_xb, r_row_y;
    logic signed [ACCW-1:0] r_za, r_sa, r_zb, r_sb;

    // span
    logic signed [15:0]     r_span_x, r_span_r, r_span_y;
    logic signed [ACCW-1:0] r_span_z, r_span_slope;
    logic [7:0]             r_row_idx;
    logic                   r_busy;

    // pixel access
    logic [AW-1:0]          r_addr;
    logic                   r_on;
    logic [DEPTH_BITS-1:0]  r_d;
    logic [AW-1:0]          r_clr_addr;

    // pending result and output register
    logic                   r_res_we;
    logic [8:0]             r_res_x;
    logic [7:0]             r_res_y;
    logic [23:0]            r_res_z;
    logic [31:0]            r_res_color;
    logic                   r_out_valid;
    logic                   r_out_we;
    logic [8:0]             r_out_x;
    logic [7:0]             r_out_y;
    logic [23:0]            r_out_z;
    logic [31:0]            r_out_color;
    logic                   r_out_done;

    // combinational
    logic                   in_acc;
    logic                   out_free;
    logic                   div_start, div_done;
    logic signed [ACCW-1:0] div_num, div_quot;
    logic [16:0]            div_den;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [DEPTH_BITS-1:0]  mem_wdata;
    logic [DEPTH_BITS-1:0]  mem_rdata;
    logic                   a_switch, a_end;
    logic signed [15:0]     srt_x [3];
    logic signed [15:0]     srt_y [3];
    logic [DEPTH_BITS-1:0]  srt_z [3];
    logic signed [15:0]     chk_x, chk_y;
    logic [WW-1:0]          w_eff;
    logic [HW-1:0]          h_eff;
    logic                   chk_on;
    logic [AW-1:0]          chk_idx;
    logic [YW+WW-1:0]       chk_prod;
    logic                   span_left_a;
    logic [31:0]            d_wide;

    function automatic logic signed [ACCW-1:0] edge_num(input logic [DEPTH_BITS-1:0] z_from,
                                                        input logic [DEPTH_BITS-1:0] z_to);
        logic signed [DEPTH_BITS:0] dz;
        dz = $signed({1'b0, z_to}) - $signed({1'b0, z_from});
        return ACCW'(dz) <<< FRAC;
    endfunction

    // Non-negative gap between two coordinates; callers guarantee order
    function automatic logic [16:0] coord_gap(input logic signed [15:0] lo,
                                              input logic signed [15:0] hi);
        logic signed [16:0] g;
        g = 17'(hi) - 17'(lo);
        return g;
    endfunction

    // Accumulator to stored depth, clamped at both ends
    function automatic logic [DEPTH_BITS-1:0] to_depth(input logic signed [ACCW-1:0] acc);
        logic [ACCW-FRAC-1:0] v;
        v = acc[ACCW-1:FRAC];
        if (acc < 0) begin
            return '0;
        end
        return (v > (ACCW-FRAC)'(DMAX)) ? DMAX : DEPTH_BITS'(v);
    endfunction

    tsdr_divider #(
        .NUM_W (ACCW),
        .DEN_W (17)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    tsdr_depth_mem #(
        .ADDR_W (AW),
        .DATA_W (DEPTH_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Sort by ascending y: swap 0/1, then 0/2, then 1/2
    always_comb begin
        logic signed [15:0]    tx, ty;
        logic [DEPTH_BITS-1:0] tz;
        tx = '0;
        ty = '0;
        tz = '0;
        for (int i = 0; i < 3; i++) begin
            srt_x[i] = r_in_x[i];
            srt_y[i] = r_in_y[i];
            srt_z[i] = r_in_z[i];
        end
        if (srt_y[1] < srt_y[0]) begin
            tx = srt_x[0]; ty = srt_y[0]; tz = srt_z[0];
            srt_x[0] = srt_x[1]; srt_y[0] = srt_y[1]; srt_z[0] = srt_z[1];
            srt_x[1] = tx; srt_y[1] = ty; srt_z[1] = tz;
        end
        if (srt_y[2] < srt_y[0]) begin
            tx = srt_x[0]; ty = srt_y[0]; tz = srt_z[0];
            srt_x[0] = srt_x[2]; srt_y[0] = srt_y[2]; srt_z[0] = srt_z[2];
            srt_x[2] = tx; srt_y[2] = ty; srt_z[2] = tz;
        end
        if (srt_y[2] < srt_y[1]) begin
            tx = srt_x[1]; ty = srt_y[1]; tz = srt_z[1];
            srt_x[1] = srt_x[2]; srt_y[1] = srt_y[2]; srt_z[1] = srt_z[2];
            srt_x[2] = tx; srt_y[2] = ty; srt_z[2] = tz;
        end
    end

    // Screen test and linear address, shared by depth set and pixel step
    always_comb begin
        logic [CWW-1:0] sw_ext;
        logic [CHW-1:0] sh_ext;
        sw_ext   = CWW'(r_screen_w);
        sh_ext   = CHW'(r_screen_h);
        w_eff    = (sw_ext > CWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(sw_ext);
        h_eff    = (sh_ext > CHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(sh_ext);
        chk_x    = (r_state == tsdr_pkg::S_SET) ? r_in_x[0] : r_span_x;
        chk_y    = (r_state == tsdr_pkg::S_SET) ? r_in_y[0] : r_span_y;
        chk_on   = !chk_x[15] && !chk_y[15]
                && (KXW'(chk_x[14:0]) < KXW'(w_eff))
                && (KYW'(chk_y[14:0]) < KYW'(h_eff));
        chk_prod = chk_y[YW-1:0] * w_eff;
        chk_idx  = AW'(chk_prod) + AW'(chk_x[XW-1:0]);
    end

    assign a_switch    = !r_wa.leg && r_wa.x == r_vx[1] && r_wa.y == r_vy[1];
    assign a_end       = r_wa.x == r_vx[2] && r_wa.y == r_vy[2];
    assign span_left_a = r_xa < r_xb;
    assign d_wide      = 32'(r_d);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsdr_pkg::S_CLEAR: begin
                if (r_clr_addr == AW'(ENTRIES - 1)) n_state = tsdr_pkg::S_IDLE;
            end
            tsdr_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (tsdr_pkg::t_cmd'(i_s_axis_tuser))
                        tsdr_pkg::CMD_LOAD:      n_state = tsdr_pkg::S_SORT;
                        tsdr_pkg::CMD_STEP:      n_state = r_busy ? tsdr_pkg::S_ADDR
                                                                  : tsdr_pkg::S_EMIT;
                        tsdr_pkg::CMD_SET_DEPTH: n_state = tsdr_pkg::S_SET;
                        default:                 n_state = tsdr_pkg::S_EMIT;
                    endcase
                end
            end
            tsdr_pkg::S_SORT:     n_state = tsdr_pkg::S_INIT;
            tsdr_pkg::S_INIT:     n_state = tsdr_pkg::S_DIV01;
            tsdr_pkg::S_DIV01:    if (div_done) n_state = tsdr_pkg::S_DIV02;
            tsdr_pkg::S_DIV02:    if (div_done) n_state = tsdr_pkg::S_ROW_A;
            tsdr_pkg::S_ROW_A: begin
                if (a_switch)                  n_state = tsdr_pkg::S_SLOPE12;
                else if (a_end)                n_state = tsdr_pkg::S_EMIT;
                else if (tsdr_pkg::walk_moves(r_wa)) n_state = tsdr_pkg::S_ROW_B;
            end
            tsdr_pkg::S_SLOPE12:  if (div_done) n_state = tsdr_pkg::S_ROW_A;
            tsdr_pkg::S_ROW_B: begin
                if (tsdr_pkg::walk_moves(r_wb)) n_state = tsdr_pkg::S_SPAN;
            end
            tsdr_pkg::S_SPAN:     n_state = tsdr_pkg::S_SPAN_DIV;
            tsdr_pkg::S_SPAN_DIV: if (div_done) n_state = tsdr_pkg::S_EMIT;
            tsdr_pkg::S_ADDR:     n_state = tsdr_pkg::S_READ;
            tsdr_pkg::S_READ:     n_state = tsdr_pkg::S_CMP;
            tsdr_pkg::S_CMP: begin
                n_state = (r_span_x >= r_span_r) ? tsdr_pkg::S_ROW_A : tsdr_pkg::S_EMIT;
            end
            tsdr_pkg::S_SET:      n_state = tsdr_pkg::S_EMIT;
            tsdr_pkg::S_EMIT:     if (out_free) n_state = tsdr_pkg::S_IDLE;
            default:              n_state = tsdr_pkg::S_IDLE;
        endcase
    end

    // control outputs: handshake, divider feed, depth store writes
    always_comb begin
        o_s_axis_tready = r_state == tsdr_pkg::S_IDLE;
        div_start       = 1'b0;
        div_num         = edge_num(r_vz[0], r_vz[1]);
        div_den         = coord_gap(r_vy[0], r_vy[1]);
        mem_we          = 1'b0;
        mem_waddr       = r_addr;
        mem_wdata       = r_d;
        unique case (r_state)
            tsdr_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = DMAX;
            end
            tsdr_pkg::S_INIT: begin
                div_start = 1'b1;
            end
            tsdr_pkg::S_DIV01: begin
                div_start = div_done;
                div_num   = edge_num(r_vz[0], r_vz[2]);
                div_den   = coord_gap(r_vy[0], r_vy[2]);
            end
            tsdr_pkg::S_ROW_A: begin
                div_start = a_switch;
                div_num   = edge_num(r_vz[1], r_vz[2]);
                div_den   = coord_gap(r_vy[1], r_vy[2]);
            end
            tsdr_pkg::S_SPAN: begin
                div_start = 1'b1;
                div_num   = span_left_a ? r_zb - r_za : r_za - r_zb;
                div_den   = span_left_a ? coord_gap(r_xa, r_xb) : coord_gap(r_xb, r_xa);
            end
            tsdr_pkg::S_CMP: begin
                mem_we = r_on && (mem_rdata > r_d);
            end
            tsdr_pkg::S_SET: begin
                mem_we    = chk_on;
                mem_waddr = chk_idx;
                mem_wdata = r_in_z[0];
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsdr_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_screen_w  <= tsdr_pkg::SCREEN_WIDTH_RST;
            r_screen_h  <= tsdr_pkg::SCREEN_HEIGHT_RST;
        end else begin
            r_state <= n_state;
            if (r_state == tsdr_pkg::S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            // configuration is taken in any state
            if (i_cfg_we) begin
                if (i_cfg_addr == tsdr_pkg::CFG_SCREEN_WIDTH) r_screen_w <= i_cfg_wdata;
                else                                          r_screen_h <= i_cfg_wdata[8:0];
            end
            if (r_state == tsdr_pkg::S_INIT) r_busy <= 1'b1;
            if (r_state == tsdr_pkg::S_ROW_A && !a_switch && a_end) r_busy <= 1'b0;
            // output register: load from a finished word, else drop on take
            if (r_state == tsdr_pkg::S_EMIT && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_axis_tready)   r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            tsdr_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_res_we <= 1'b0;
                    r_res_x  <= '0;
                    r_res_y  <= '0;
                    r_res_z  <= '0;
                    r_res_color <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_in_x[i] <= i_s_axis_tdata[56*i +: 16];
                        r_in_y[i] <= i_s_axis_tdata[56*i+16 +: 16];
                        r_in_z[i] <= DEPTH_BITS'(32'(i_s_axis_tdata[56*i+32 +: 24]));
                    end
                end
            end
            tsdr_pkg::S_SORT: begin
                for (int i = 0; i < 3; i++) begin
                    r_vx[i] <= srt_x[i];
                    r_vy[i] <= srt_y[i];
                    r_vz[i] <= srt_z[i];
                end
            end
            tsdr_pkg::S_INIT: begin
                tsdr_pkg::t_walker w0;
                w0      = '0;
                w0.x    = r_vx[0];
                w0.y    = r_vy[0];
                r_wa    <= tsdr_pkg::walk_aim(w0, r_vx[1], r_vy[1]);
                r_wb    <= tsdr_pkg::walk_aim(w0, r_vx[2], r_vy[2]);
                r_za    <= ACCW'(r_vz[0]) <<< FRAC;
                r_zb    <= ACCW'(r_vz[0]) <<< FRAC;
                r_row_idx <= '0;
            end
            tsdr_pkg::S_DIV01: begin
                if (div_done) r_sa <= div_quot;
            end
            tsdr_pkg::S_DIV02: begin
                if (div_done) begin
                    r_sb    <= div_quot;
                    r_row_y <= r_wa.y;
                end
            end
            tsdr_pkg::S_ROW_A: begin
                r_xa <= r_wa.x;
                if (a_switch) begin
                    tsdr_pkg::t_walker wn;
                    wn     = tsdr_pkg::walk_aim(r_wa, r_vx[2], r_vy[2]);
                    wn.leg = 1'b1;
                    r_wa   <= wn;
                end else if (!a_end) begin
                    r_wa <= tsdr_pkg::walk_step(r_wa);
                end
            end
            tsdr_pkg::S_SLOPE12: begin
                if (div_done) r_sa <= div_quot;
            end
            tsdr_pkg::S_ROW_B: begin
                r_xb <= r_wb.x;
                r_wb <= tsdr_pkg::walk_step(r_wb);
            end
            tsdr_pkg::S_SPAN: begin
                r_span_y <= r_row_y;
                // equal x starts the span at edge B
                r_span_x <= span_left_a ? r_xa : r_xb;
                r_span_r <= span_left_a ? r_xb : r_xa;
                r_span_z <= span_left_a ? r_za : r_zb;
            end
            tsdr_pkg::S_SPAN_DIV: begin
                if (div_done) r_span_slope <= div_quot;
            end
            tsdr_pkg::S_ADDR: begin
                r_on   <= chk_on;
                r_addr <= chk_idx;
                r_d    <= to_depth(r_span_z);
            end
            tsdr_pkg::S_CMP: begin
                if (mem_we) begin
                    r_res_we    <= 1'b1;
                    r_res_x     <= r_span_x[8:0];
                    r_res_y     <= r_span_y[7:0];
                    r_res_z     <= d_wide[23:0];
                    r_res_color <= tsdr_pkg::COLOR_BASE + 32'(r_row_idx);
                end
                r_span_z <= r_span_z + r_span_slope;
                if (r_span_x >= r_span_r) begin
                    // row finished: advance edge depths and walk the next row
                    r_row_idx <= r_row_idx + 1'b1;
                    r_za      <= r_za + r_sa;
                    r_zb      <= r_zb + r_sb;
                    r_row_y   <= r_wa.y;
                end else begin
                    r_span_x <= r_span_x + 16'sd1;
                end
            end
            tsdr_pkg::S_EMIT: begin
                if (out_free) begin
                    r_out_we    <= r_res_we;
                    r_out_x     <= r_res_x;
                    r_out_y     <= r_res_y;
                    r_out_z     <= r_res_z;
                    r_out_color <= r_res_color;
                    r_out_done  <= !r_busy;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_color, r_out_z, r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_we;
    assign o_m_axis_tlast  = r_out_done;

endmodule

### sv/tsdr_checker.sv
// Port-level checks for the rasteriser, bound onto the top level.
module tsdr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [167:0] i_s_axis_tdata,
    input logic [1:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [79:0]  o_m_axis_tdata,
    input logic         o_m_axis_tuser,
    input logic         o_m_axis_tlast,
    input logic         i_cfg_we,
    input logic         i_cfg_addr,
    input logic [9:0]   i_cfg_wdata
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // one word in flight: an accepted word closes the input side next cycle
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again before its result");

    // no write means zero pixel fields
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 80'd0)
        else $error("pixel fields set without a write");

    // written colour keeps its fixed upper bits
    a_color_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[72:61] == 12'hFFF)
        else $error("pixel colour base wrong");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result word present after reset");

endmodule

bind triangle_scanline_depth_raster_unit tsdr_checker u_tsdr_checker (.*);
